>>> rtl/cpr_pkg.sv
// Shared types and constants of the CORDIC point rotation block.
package cpr_pkg;

    localparam int COORD_W = 32;
    localparam int STEP_W  = 11;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int ANG_W   = 16;
    localparam int CS_W    = 18;
    localparam int ATAN_N  = 15;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [ANG_W-1:0]   t_ang;
    typedef logic signed [CS_W-1:0]    t_cs;

    // Starting cosine, already scaled down by the CORDIC gain (one is 32768).
    localparam t_cs START_COS = 18'sd19898;

    // Arctangent of 2^-i, with 32768 standing for a half turn.
    localparam t_ang ATAN_TABLE [ATAN_N] = '{
        16'sd8192, 16'sd4836, 16'sd2555, 16'sd1297, 16'sd651, 16'sd326, 16'sd163,
        16'sd81, 16'sd41, 16'sd20, 16'sd10, 16'sd5, 16'sd3, 16'sd1, 16'sd1
    };

    // Payload handed along the chain of rotation cells.
    typedef struct packed {
        t_ang   angle;
        t_cs    c;
        t_cs    s;
        t_coord cx;
        t_coord cy;
        t_diff  dx;
        t_diff  dy;
    } t_rot;

    // Rotated offset together with the center it is added back to.
    typedef struct packed {
        t_coord cx;
        t_coord cy;
        t_coord ox;
        t_coord oy;
    } t_off;

endpackage

>>> rtl/cordic_point_rotation.sv
// Top level of the CORDIC point rotation block: front stages, cell chain, back stages.
//
// Rotates a point about a center by a signed step, 3000 steps to a half turn,
// and returns the rotated point wrapped to 32 bits. The block is a fully
// registered pipeline that takes one transfer per clock and delivers one per
// clock while the output side is ready. An input transfer passes through the
// front stages, which scale the step and form the offset, then through one
// register-bounded CORDIC cell per iteration, then through the back stages,
// which multiply, sum and rescale, and finally into the output register, where
// the center is added back. Each cell performs one micro-rotation per clock
// while the pipeline advances. A skid register behind the output register
// lets the block accept one more transfer while a finished result waits;
// once the skid register is occupied the input ready drops and the whole
// pipeline holds until the consumer takes a result.
// There are no configuration registers and no state carried between items.
module cordic_point_rotation #(
    parameter int ITERATIONS = 15
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [31:0]                 i_center_x,
    input  logic signed [31:0]                 i_center_y,
    input  logic signed [31:0]                 i_point_x,
    input  logic signed [31:0]                 i_point_y,
    input  logic signed [cpr_pkg::STEP_W-1:0]  i_turn_step,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [31:0]                 o_rotated_x,
    output logic signed [31:0]                 o_rotated_y
);
    import cpr_pkg::*;

    // The whole pipeline advances together whenever the skid register is free.
    logic pipe_en;

    logic chain_valid [ITERATIONS+1];
    t_rot chain_data  [ITERATIONS+1];

    logic back_valid;
    t_off back_data;

    logic   r_out_valid, n_out_valid;
    t_coord r_out_x, n_out_x, r_out_y, n_out_y;
    logic   r_skid_valid, n_skid_valid;
    t_coord r_skid_x, n_skid_x, r_skid_y, n_skid_y;
    t_coord sum_x, sum_y;
    logic   incoming;

    assign pipe_en    = !r_skid_valid;
    assign o_in_ready = pipe_en;

    cpr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (pipe_en),
        .i_valid    (i_in_valid),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .i_turn_step(i_turn_step),
        .o_valid    (chain_valid[0]),
        .o_data     (chain_data[0])
    );

    // One cell per micro-rotation; cell g uses shift g and the g-th arctangent.
    for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
        cpr_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (pipe_en),
            .i_valid(chain_valid[g]),
            .i_data (chain_data[g]),
            .o_valid(chain_valid[g+1]),
            .o_data (chain_data[g+1])
        );
    end

    cpr_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (pipe_en),
        .i_valid(chain_valid[ITERATIONS]),
        .i_data (chain_data[ITERATIONS]),
        .o_valid(back_valid),
        .o_data (back_data)
    );

    // The rotated offset is added back to the center, wrapping at 32 bits.
    // A result leaving the pipeline goes to the output register when that is
    // free or being emptied, and otherwise parks in the skid register.
    always_comb begin
        sum_x        = back_data.cx + back_data.ox;
        sum_y        = back_data.cy + back_data.oy;
        incoming     = pipe_en && back_valid;
        n_out_valid  = r_out_valid;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_skid_valid = r_skid_valid;
        n_skid_x     = r_skid_x;
        n_skid_y     = r_skid_y;
        if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_x      = r_skid_x;
                n_out_y      = r_skid_y;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = incoming;
                n_out_x     = sum_x;
                n_out_y     = sum_y;
            end
        end else if (incoming) begin
            n_skid_valid = 1'b1;
            n_skid_x     = sum_x;
            n_skid_y     = sum_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_x  <= n_out_x;
        r_out_y  <= n_out_y;
        r_skid_x <= n_skid_x;
        r_skid_y <= n_skid_y;
    end

    assign o_out_valid = r_out_valid;
    assign o_rotated_x = r_out_x;
    assign o_rotated_y = r_out_y;

    // The skid register only ever fills behind a waiting output register.
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    // A result arriving at a stalled output must land in the skid register.
    a_stall_to_skid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && !r_skid_valid && back_valid) |=> r_skid_valid)
        else $error("result from the pipeline was dropped at a stalled output");

    // Once the consumer takes a result, a parked result moves up and frees the skid.
    a_skid_drains : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid register did not drain into the output register");

    // The input side is held off exactly while the skid register is occupied.
    a_ready_tracks_skid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && back_valid && !r_skid_valid) |=> !o_in_ready)
        else $error("input accepted while the skid register is full");

endmodule

>>> rtl/cpr_front.sv
// Input stages: scales the angle step to a binary angle and forms the offset.
module cpr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  cpr_pkg::t_coord i_center_x,
    input  cpr_pkg::t_coord i_center_y,
    input  cpr_pkg::t_coord i_point_x,
    input  cpr_pkg::t_coord i_point_y,
    input  logic signed [cpr_pkg::STEP_W-1:0] i_turn_step,
    output logic           o_valid,
    output cpr_pkg::t_rot  o_data
);
    import cpr_pkg::*;

    // step * 32768 / 3000 equals |step| * RECIP >> 20 exactly over the step range.
    localparam int RECIP_W = 24;
    localparam int PROD_W  = STEP_W + RECIP_W;
    localparam int Q_SH    = 20;
    localparam logic [RECIP_W-1:0] RECIP = 24'd11453247;

    logic [STEP_W-1:0] mag;
    logic [PROD_W-1:0] n_prod;
    logic [PROD_W-1:0] r_prod;
    logic              r_neg;
    logic              r_valid0;
    t_coord            r_cx, r_cy;
    t_diff             r_dx, r_dy;
    logic [ANG_W-1:0]  quot;
    t_rot              n_data;
    t_rot              r_data;
    logic              r_valid1;

    always_comb begin
        mag    = i_turn_step[STEP_W-1] ? STEP_W'(-i_turn_step) : STEP_W'(i_turn_step);
        n_prod = PROD_W'(mag) * PROD_W'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (i_en) begin
            r_valid0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_neg  <= i_turn_step[STEP_W-1];
            r_cx   <= i_center_x;
            r_cy   <= i_center_y;
            r_dx   <= DIFF_W'(i_point_x) - DIFF_W'(i_center_x);
            r_dy   <= DIFF_W'(i_point_y) - DIFF_W'(i_center_y);
        end
    end

    always_comb begin
        quot         = ANG_W'(r_prod[PROD_W-1:Q_SH]);
        n_data.angle = r_neg ? t_ang'(-quot) : t_ang'(quot);
        n_data.c     = START_COS;
        n_data.s     = '0;
        n_data.cx    = r_cx;
        n_data.cy    = r_cy;
        n_data.dx    = r_dx;
        n_data.dy    = r_dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= r_valid0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid1;
    assign o_data  = r_data;

endmodule

>>> rtl/cpr_cell.sv
// One CORDIC micro-rotation cell with its own pipeline register.
module cpr_cell #(
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  cpr_pkg::t_rot i_data,
    output logic          o_valid,
    output cpr_pkg::t_rot o_data
);
    import cpr_pkg::*;

    // Adding this before the arithmetic shift makes it truncate toward zero.
    localparam t_cs  BIAS   = t_cs'((1 << IDX) - 1);
    localparam t_ang ATAN_I = ATAN_TABLE[IDX];

    t_cs  sc, ss;
    t_rot n_data;
    t_rot r_data;
    logic r_valid;

    always_comb begin
        sc = i_data.c[CS_W-1] ? ((i_data.c + BIAS) >>> IDX) : (i_data.c >>> IDX);
        ss = i_data.s[CS_W-1] ? ((i_data.s + BIAS) >>> IDX) : (i_data.s >>> IDX);
        n_data = i_data;
        if (!i_data.angle[ANG_W-1]) begin
            n_data.c     = i_data.c - ss;
            n_data.s     = i_data.s + sc;
            n_data.angle = i_data.angle - ATAN_I;
        end else begin
            n_data.c     = i_data.c + ss;
            n_data.s     = i_data.s - sc;
            n_data.angle = i_data.angle + ATAN_I;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/cpr_back.sv
// Output stages: rotates the offset by the cosine and sine and rescales it.
module cpr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  cpr_pkg::t_rot i_data,
    output logic          o_valid,
    output cpr_pkg::t_off o_data
);
    import cpr_pkg::*;

    localparam int PROD_W  = DIFF_W + CS_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int FRAC_SH = 15;
    localparam logic signed [SUM_W-1:0] FRAC_MASK = SUM_W'((1 << FRAC_SH) - 1);

    logic signed [PROD_W-1:0] r_pxc, r_pys, r_pxs, r_pyc;
    logic signed [SUM_W-1:0]  r_rx, r_ry;
    logic signed [SUM_W-1:0]  adj_x, adj_y;
    t_coord r_cx_a, r_cy_a, r_cx_b, r_cy_b;
    t_off   r_data;
    logic [2:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_comb begin
        adj_x = r_rx + (r_rx[SUM_W-1] ? FRAC_MASK : '0);
        adj_y = r_ry + (r_ry[SUM_W-1] ? FRAC_MASK : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxc     <= PROD_W'(i_data.dx) * PROD_W'(i_data.c);
            r_pys     <= PROD_W'(i_data.dy) * PROD_W'(i_data.s);
            r_pxs     <= PROD_W'(i_data.dx) * PROD_W'(i_data.s);
            r_pyc     <= PROD_W'(i_data.dy) * PROD_W'(i_data.c);
            r_cx_a    <= i_data.cx;
            r_cy_a    <= i_data.cy;
            r_rx      <= SUM_W'(r_pxc) - SUM_W'(r_pys);
            r_ry      <= SUM_W'(r_pxs) + SUM_W'(r_pyc);
            r_cx_b    <= r_cx_a;
            r_cy_b    <= r_cy_a;
            r_data.cx <= r_cx_b;
            r_data.cy <= r_cy_b;
            r_data.ox <= adj_x[FRAC_SH+COORD_W-1:FRAC_SH];
            r_data.oy <= adj_y[FRAC_SH+COORD_W-1:FRAC_SH];
        end
    end

    assign o_valid = r_valid[2];
    assign o_data  = r_data;

endmodule
